// File: hdl/push_relabel_step_engine_top_defines.svh
// ---------------------------------------------------------------------------
// Push-relabel step engine assertion macros
// Concurrent checks, sampled on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef PUSH_RELABEL_STEP_ENGINE_TOP_DEFINES_SVH
`define PUSH_RELABEL_STEP_ENGINE_TOP_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define PRSE_ASSERT_IMP(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("push_relabel_step_engine: check failed");
// next-cycle implication
`define PRSE_ASSERT_NXT(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("push_relabel_step_engine: check failed");
`else
`define PRSE_ASSERT_IMP(lbl, a, c)
`define PRSE_ASSERT_NXT(lbl, a, c)
`endif

`endif

// File: hdl/prse_pkg.sv
// ---------------------------------------------------------------------------
// Push-relabel step engine package
// Operation, status and state codes plus fixed field widths.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package prse_pkg;

    localparam int EXCESS_W = 20;
    localparam int LABEL_W  = 6;
    localparam logic [EXCESS_W-1:0] EXCESS_MAX = '1;
    localparam logic [LABEL_W-1:0]  LABEL_MAX  = '1;

    typedef enum logic [1:0] {
        OP_ADD_EDGE = 2'd0,
        OP_PREPROC  = 2'd1,
        OP_STEP     = 2'd2,
        OP_NONE     = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_LOADED    = 2'd0,
        ST_PUSHED    = 2'd1,
        ST_RELABELED = 2'd2,
        ST_NO_ARC    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CFG_VERTEX_COUNT  = 2'd0,
        CFG_SOURCE_VERTEX = 2'd1,
        CFG_SINK_VERTEX   = 2'd2,
        CFG_UNUSED        = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_ADD1,
        S_ADD2,
        S_PRE,
        S_PR_RD,
        S_PR_WR,
        S_PR_RV,
        S_RDU,
        S_SCAN,
        S_P1,
        S_P2,
        S_P3,
        S_RELAB,
        S_FIN,
        S_DONE
    } state_t;

endpackage

// File: hdl/push_relabel_step_engine_top.sv
// ---------------------------------------------------------------------------
// Push-relabel step engine
// Edge matrix and vertex label/excess stores in synchronous memories,
// sequenced read-modify-write for add edge, preprocess and push/relabel.
// ---------------------------------------------------------------------------
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  config  | cfg_we, cfg_addr, cfg_wdata               | in
//  input   | in_valid/in_ready, operation .. capacity  | in
//  output  | out_valid/out_ready, status .. sink_excess| out
//
// Add edge writes the forward and then the reverse edge; preprocess labels
// the source, then saturates each of its edges in turn; a step reads the
// vertex, scans its row through the edge and label memories, then pushes or
// relabels. After reset a clearing pass over the whole edge matrix runs with
// in_ready low. A stalled output holds the engine before it returns to idle;
// a new beat is accepted while the previous result still waits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "push_relabel_step_engine_top_defines.svh"

module push_relabel_step_engine_top
    import prse_pkg::*;
#(
    parameter int MAX_VERTICES = 16,
    parameter int CAP_BITS     = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_addr,
    input  logic [4:0]          cfg_wdata,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          operation,
    input  logic [3:0]          from_vertex,
    input  logic [3:0]          to_vertex,
    input  logic [15:0]         edge_capacity,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          status,
    output logic [3:0]          pushed_to,
    output logic [15:0]         push_amount,
    output logic [LABEL_W-1:0]  node_label,
    output logic [EXCESS_W-1:0] sink_excess
);

    localparam int VW    = $clog2(MAX_VERTICES);
    localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
    localparam int EAW   = $clog2(DEPTH);
    localparam int FW    = CAP_BITS + 1;
    localparam int RW    = CAP_BITS + 2;
    localparam int XW    = (CAP_BITS > EXCESS_W ? CAP_BITS : EXCESS_W) + 1;
    localparam logic [CAP_BITS-1:0] CAP_MAX = '1;
    localparam logic [FW-1:0] FLOW_MIN = {1'b1, {CAP_BITS{1'b0}}};
    localparam logic [RW-1:0] FLOW_MIN_R = {2'b11, {CAP_BITS{1'b0}}};

    // memories
    logic                present_mem [DEPTH];
    logic [CAP_BITS-1:0] cap_mem     [DEPTH];
    logic [FW-1:0]       flow_mem    [DEPTH];
    logic [LABEL_W-1:0]  height_mem  [MAX_VERTICES];
    logic [EXCESS_W-1:0] surplus_mem [MAX_VERTICES];

    logic                e_we, e_re, f_we, f_re, h_we, h_re, s_we, s_re;
    logic [EAW-1:0]      e_wa, e_ra, f_wa, f_ra;
    logic                e_wd_p;
    logic [CAP_BITS-1:0] e_wd_c;
    logic [FW-1:0]       f_wd;
    logic [VW-1:0]       h_wa, h_ra, s_wa, s_ra;
    logic [LABEL_W-1:0]  h_wd;
    logic [EXCESS_W-1:0] s_wd;
    logic                prs_rd;
    logic [CAP_BITS-1:0] cap_rd;
    logic [FW-1:0]       flow_rd;
    logic [LABEL_W-1:0]  hgt_rd;
    logic [EXCESS_W-1:0] sur_rd;

    always_ff @(posedge clk)
    begin
        if (e_we)
        begin
            present_mem[e_wa] <= e_wd_p;
            cap_mem[e_wa]     <= e_wd_c;
        end
        if (e_re)
        begin
            prs_rd <= present_mem[e_ra];
            cap_rd <= cap_mem[e_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (f_we)
            flow_mem[f_wa] <= f_wd;
        if (f_re)
            flow_rd <= flow_mem[f_ra];
    end

    always_ff @(posedge clk)
    begin
        if (h_we)
            height_mem[h_wa] <= h_wd;
        if (h_re)
            hgt_rd <= height_mem[h_ra];
    end

    always_ff @(posedge clk)
    begin
        if (s_we)
            surplus_mem[s_wa] <= s_wd;
        if (s_re)
            sur_rd <= surplus_mem[s_ra];
    end

    function automatic logic [EAW-1:0] eaddr(input logic [VW-1:0] a, input logic [VW-1:0] b);
        return EAW'(a) * EAW'(MAX_VERTICES) + EAW'(b);
    endfunction

    function automatic logic [EXCESS_W-1:0] sat_ex(input logic [XW-1:0] x);
        return (x > XW'(EXCESS_MAX)) ? EXCESS_MAX : EXCESS_W'(x);
    endfunction

    // registers
    state_t              state_reg, state_next;
    logic [4:0]          vcount_reg;
    logic [3:0]          source_reg, sink_reg;
    logic [EAW-1:0]      clr_reg, clr_next;
    logic [VW-1:0]       u_reg, u_next, v_reg, v_next;
    logic [CAP_BITS-1:0] cap_reg, cap_next;
    logic [VW:0]         iss_reg, iss_next;
    logic                ev_valid_reg, ev_valid_next;
    logic [VW-1:0]       ev_idx_reg, ev_idx_next;
    logic [LABEL_W-1:0]  hu_reg, hu_next;
    logic [EXCESS_W-1:0] exu_reg, exu_next;
    logic                found_reg, found_next;
    logic [LABEL_W-1:0]  best_reg, best_next;
    logic [VW-1:0]       to_reg, to_next;
    logic [FW-1:0]       resid_reg, resid_next;
    logic [FW-1:0]       flowe_reg, flowe_next;
    logic [CAP_BITS-1:0] amt_reg, amt_next;
    logic [FW-1:0]       rflow_reg, rflow_next;
    logic [CAP_BITS-1:0] pc_reg, pc_next;
    logic                pp_reg, pp_next;
    status_t             res_status_reg, res_status_next;
    logic [LABEL_W-1:0]  res_label_reg, res_label_next;
    logic                res_push_reg, res_push_next;
    logic                out_valid_reg, out_valid_next;
    status_t             status_reg, status_next;
    logic [3:0]          pushed_to_reg, pushed_to_next;
    logic [15:0]         push_amount_reg, push_amount_next;
    logic [LABEL_W-1:0]  node_label_reg, node_label_next;
    logic [EXCESS_W-1:0] sink_excess_reg, sink_excess_next;

    // decoded conditions
    logic [6:0]          n7;
    logic                in_beat, out_free, u_ok, v_ok, s_ok, sink_ok;
    logic                resid_ok, adm, ev_last, iss_more, pr_last;
    logic [RW-1:0]       flow_x, cap_x, resid_x;
    logic [CAP_BITS-1:0] cap_in;
    logic [XW-1:0]       amt_x;
    logic [CAP_BITS-1:0] amt_c;
    logic [RW-1:0]       rf_x;
    logic [6:0]          best_p1;

    assign n7       = (7'(vcount_reg) < 7'(MAX_VERTICES)) ? 7'(vcount_reg) : 7'(MAX_VERTICES);
    assign in_ready = (state_reg == S_IDLE);
    assign in_beat  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign u_ok     = 7'(from_vertex) < n7;
    assign v_ok     = 7'(to_vertex) < n7;
    assign s_ok     = 7'(source_reg) < n7;
    assign sink_ok  = 7'(sink_reg) < 7'(MAX_VERTICES);
    assign cap_in   = (32'(edge_capacity) > 32'(CAP_MAX)) ? CAP_MAX : CAP_BITS'(edge_capacity);

    assign flow_x   = {flow_rd[FW-1], flow_rd};
    assign cap_x    = {2'b00, cap_rd};
    assign resid_ok = prs_rd && ($signed(flow_x) < $signed(cap_x));
    assign resid_x  = cap_x - flow_x;
    assign adm      = ev_valid_reg && resid_ok && (hu_reg > hgt_rd);
    assign ev_last  = ev_valid_reg && ((7'(ev_idx_reg) + 7'd1) == n7);
    assign iss_more = 7'(iss_reg) < n7;
    assign pr_last  = (7'(iss_reg) + 7'd1) == n7;

    assign amt_x    = (XW'(resid_reg) < XW'(exu_reg)) ? XW'(resid_reg) : XW'(exu_reg);
    assign amt_c    = (amt_x > XW'(CAP_MAX)) ? CAP_MAX : CAP_BITS'(amt_x);
    assign rf_x     = {rflow_reg[FW-1], rflow_reg} - {2'b00, amt_reg};
    assign best_p1  = 7'(best_reg) + 7'd1;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLR:   if (clr_reg == EAW'(DEPTH - 1)) state_next = S_IDLE;
            S_IDLE:
            begin
                if (in_beat)
                begin
                    unique case (op_t'(operation))
                        OP_ADD_EDGE: state_next = (u_ok && v_ok) ? S_ADD1 : S_FIN;
                        OP_PREPROC:  state_next = s_ok ? S_PRE : S_FIN;
                        OP_STEP:     state_next = u_ok ? S_RDU : S_FIN;
                        default:     state_next = S_FIN;
                    endcase
                end
            end
            S_ADD1:  state_next = S_ADD2;
            S_ADD2:  state_next = S_FIN;
            S_PRE:   state_next = S_PR_RD;
            S_PR_RD: state_next = S_PR_WR;
            S_PR_WR: state_next = S_PR_RV;
            S_PR_RV: state_next = pr_last ? S_FIN : S_PR_RD;
            S_RDU:   state_next = S_SCAN;
            S_SCAN:
            begin
                if (adm)
                    state_next = S_P1;
                else if (ev_last)
                    state_next = S_RELAB;
            end
            S_P1:    state_next = S_P2;
            S_P2:    state_next = S_P3;
            S_P3:    state_next = S_FIN;
            S_RELAB: state_next = S_FIN;
            S_FIN:   state_next = S_DONE;
            S_DONE:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        e_we = 1'b0; e_re = 1'b0; f_we = 1'b0; f_re = 1'b0;
        h_we = 1'b0; h_re = 1'b0; s_we = 1'b0; s_re = 1'b0;
        e_wa = clr_reg; e_ra = eaddr(u_reg, iss_reg[VW-1:0]);
        f_wa = clr_reg; f_ra = eaddr(u_reg, iss_reg[VW-1:0]);
        e_wd_p = 1'b0; e_wd_c = '0; f_wd = '0;
        h_wa = VW'(clr_reg); h_ra = iss_reg[VW-1:0]; h_wd = '0;
        s_wa = VW'(clr_reg); s_ra = u_reg; s_wd = '0;

        clr_next = clr_reg; u_next = u_reg; v_next = v_reg; cap_next = cap_reg;
        iss_next = iss_reg; ev_valid_next = 1'b0; ev_idx_next = ev_idx_reg;
        hu_next = hu_reg; exu_next = exu_reg; found_next = found_reg;
        best_next = best_reg; to_next = to_reg; resid_next = resid_reg;
        flowe_next = flowe_reg; amt_next = amt_reg; rflow_next = rflow_reg;
        pc_next = pc_reg; pp_next = pp_reg;
        res_status_next = res_status_reg; res_label_next = res_label_reg;
        res_push_next = res_push_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next = status_reg; pushed_to_next = pushed_to_reg;
        push_amount_next = push_amount_reg; node_label_next = node_label_reg;
        sink_excess_next = sink_excess_reg;

        unique case (state_reg)
            S_CLR:
            begin
                e_we = 1'b1;
                f_we = 1'b1;
                h_we = (32'(clr_reg) < MAX_VERTICES);
                s_we = h_we;
                clr_next = clr_reg + EAW'(1);
            end
            S_IDLE:
            begin
                if (in_beat)
                begin
                    u_next = VW'(from_vertex);
                    v_next = VW'(to_vertex);
                    cap_next = cap_in;
                    iss_next = '0;
                    found_next = 1'b0;
                    res_push_next = 1'b0;
                    res_label_next = '0;
                    res_status_next = (op_t'(operation) == OP_STEP) ? ST_NO_ARC : ST_LOADED;
                    if (op_t'(operation) == OP_PREPROC)
                        u_next = VW'(source_reg);
                end
            end
            S_ADD1:
            begin
                e_we = 1'b1; e_wa = eaddr(u_reg, v_reg); e_wd_p = 1'b1; e_wd_c = cap_reg;
                f_we = 1'b1; f_wa = eaddr(u_reg, v_reg);
            end
            S_ADD2:
            begin
                // reverse edge overwrites, a self loop ends with zero capacity
                e_we = 1'b1; e_wa = eaddr(v_reg, u_reg); e_wd_p = 1'b1;
                f_we = 1'b1; f_wa = eaddr(v_reg, u_reg);
            end
            S_PRE:
            begin
                h_we = 1'b1; h_wa = u_reg;
                h_wd = (n7 > 7'(LABEL_MAX)) ? LABEL_MAX : LABEL_W'(n7);
                res_label_next = h_wd;
            end
            S_PR_RD:
            begin
                e_re = 1'b1;
            end
            S_PR_WR:
            begin
                pp_next = prs_rd;
                pc_next = cap_rd;
                f_we = prs_rd; f_wa = eaddr(u_reg, iss_reg[VW-1:0]);
                f_wd = {1'b0, cap_rd};
                s_we = prs_rd; s_wa = iss_reg[VW-1:0]; s_wd = sat_ex(XW'(cap_rd));
            end
            S_PR_RV:
            begin
                f_we = pp_reg; f_wa = eaddr(iss_reg[VW-1:0], u_reg);
                f_wd = FW'(-{1'b0, pc_reg});
                iss_next = iss_reg + 1'b1;
            end
            S_RDU:
            begin
                h_re = 1'b1; h_ra = u_reg;
                s_re = 1'b1; s_ra = u_reg;
            end
            S_SCAN:
            begin
                if (!ev_valid_reg && iss_reg == '0)
                begin
                    hu_next = hgt_rd;
                    exu_next = sur_rd;
                end
                // issue the next neighbour while the previous one evaluates
                if (iss_more)
                begin
                    e_re = 1'b1; f_re = 1'b1; h_re = 1'b1;
                    ev_valid_next = 1'b1;
                    ev_idx_next = iss_reg[VW-1:0];
                    iss_next = iss_reg + 1'b1;
                end
                if (ev_valid_reg && resid_ok && (!found_reg || hgt_rd < best_reg))
                begin
                    found_next = 1'b1;
                    best_next = hgt_rd;
                end
                if (adm)
                begin
                    to_next = ev_idx_reg;
                    resid_next = FW'(resid_x);
                    flowe_next = flow_rd;
                    ev_valid_next = 1'b0;
                end
            end
            S_P1:
            begin
                amt_next = amt_c;
                s_we = 1'b1; s_wa = u_reg; s_wd = EXCESS_W'(XW'(exu_reg) - XW'(amt_c));
                s_re = 1'b1; s_ra = to_reg;
                f_re = 1'b1; f_ra = eaddr(to_reg, u_reg);
            end
            S_P2:
            begin
                rflow_next = flow_rd;
                s_we = 1'b1; s_wa = to_reg; s_wd = sat_ex(XW'(sur_rd) + XW'(amt_reg));
                f_we = 1'b1; f_wa = eaddr(u_reg, to_reg);
                f_wd = FW'({flowe_reg[FW-1], flowe_reg} + {2'b00, amt_reg});
            end
            S_P3:
            begin
                f_we = 1'b1; f_wa = eaddr(to_reg, u_reg);
                f_wd = ($signed(rf_x) < $signed(FLOW_MIN_R)) ? FLOW_MIN : FW'(rf_x);
                res_status_next = ST_PUSHED;
                res_label_next = hu_reg;
                res_push_next = 1'b1;
            end
            S_RELAB:
            begin
                if (found_reg)
                begin
                    h_we = 1'b1; h_wa = u_reg;
                    h_wd = (best_p1 > 7'(LABEL_MAX)) ? LABEL_MAX : LABEL_W'(best_p1);
                    res_status_next = ST_RELABELED;
                    res_label_next = h_wd;
                end
                else
                begin
                    res_status_next = ST_NO_ARC;
                    res_label_next = hu_reg;
                end
            end
            S_FIN:
            begin
                s_re = 1'b1; s_ra = VW'(sink_reg);
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next = res_status_reg;
                    pushed_to_next = res_push_reg ? 4'(to_reg) : 4'd0;
                    push_amount_next = res_push_reg ? 16'(amt_reg) : 16'd0;
                    node_label_next = res_label_reg;
                    sink_excess_next = sink_ok ? sur_rd : '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            vcount_reg    <= 5'd16;
            source_reg    <= 4'd0;
            sink_reg      <= 4'd1;
            ev_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            ev_valid_reg  <= ev_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_addr))
                    CFG_VERTEX_COUNT:  vcount_reg <= cfg_wdata;
                    CFG_SOURCE_VERTEX: source_reg <= cfg_wdata[3:0];
                    CFG_SINK_VERTEX:   sink_reg   <= cfg_wdata[3:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg           <= u_next;
        v_reg           <= v_next;
        cap_reg         <= cap_next;
        iss_reg         <= iss_next;
        ev_idx_reg      <= ev_idx_next;
        hu_reg          <= hu_next;
        exu_reg         <= exu_next;
        found_reg       <= found_next;
        best_reg        <= best_next;
        to_reg          <= to_next;
        resid_reg       <= resid_next;
        flowe_reg       <= flowe_next;
        amt_reg         <= amt_next;
        rflow_reg       <= rflow_next;
        pc_reg          <= pc_next;
        pp_reg          <= pp_next;
        res_status_reg  <= res_status_next;
        res_label_reg   <= res_label_next;
        res_push_reg    <= res_push_next;
        status_reg      <= status_next;
        pushed_to_reg   <= pushed_to_next;
        push_amount_reg <= push_amount_next;
        node_label_reg  <= node_label_next;
        sink_excess_reg <= sink_excess_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign pushed_to   = pushed_to_reg;
    assign push_amount = push_amount_reg;
    assign node_label  = node_label_reg;
    assign sink_excess = sink_excess_reg;

    // a push needs a label above its neighbour's, so never label zero
    `PRSE_ASSERT_IMP(a_push_label, out_valid && status == ST_PUSHED, node_label != '0)
    `PRSE_ASSERT_IMP(a_nopush_zero, out_valid && status != ST_PUSHED,
                     pushed_to == 4'd0 && push_amount == 16'd0)
    `PRSE_ASSERT_IMP(a_push_le_excess, state_reg == S_P2, XW'(amt_reg) <= XW'(exu_reg))
    `PRSE_ASSERT_IMP(a_scan_in_range, state_reg == S_SCAN && ev_valid_reg, 7'(ev_idx_reg) < n7)

endmodule

// File: tb/tb.sv
// ---------------------------------------------------------------------------
// Push-relabel step engine testbench
// Drives edge loads, preprocess and node steps through the valid/ready input
// channel, predicts each result from an internal copy of the flow network,
// and compares every result beat field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb
    import prse_pkg::*;
();

    localparam int NV = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  from_v;
        logic [3:0]  to_v;
        logic [15:0] cap;
    } beat_in_t;

    typedef struct packed {
        logic [1:0]  st;
        logic [3:0]  to_v;
        logic [15:0] amount;
        logic [5:0]  label;
        logic [19:0] excess;
    } beat_out_t;

    // a directed row: stimulus plus an optional literal expectation
    typedef struct {
        beat_in_t  stim;
        bit        fixed;
        beat_out_t res;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [4:0]  cfg_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  operation = '0;
    logic [3:0]  from_vertex = '0;
    logic [3:0]  to_vertex = '0;
    logic [15:0] edge_capacity = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  status;
    logic [3:0]  pushed_to;
    logic [15:0] push_amount;
    logic [5:0]  node_label;
    logic [19:0] sink_excess;

    // network mirror
    bit                 net_present [NV*NV];
    logic [15:0]        net_cap     [NV*NV];
    logic signed [16:0] net_flow    [NV*NV];
    logic [5:0]         net_height  [NV];
    logic [19:0]        net_surplus [NV];
    logic [4:0]         n_vertices;
    logic [3:0]         src_v;
    logic [3:0]         snk_v;

    beat_out_t pending_results[$];
    int  errors = 0;
    int  idle_cycles = 0;
    int  out_wait = 0;
    bit  stim_done = 1'b0;

    push_relabel_step_engine_top uut (.*);

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    function automatic logic [5:0] sat_height(int x);
        return (x > 63) ? 6'd63 : x[5:0];
    endfunction

    function automatic beat_out_t apply_op(beat_in_t b);
        beat_out_t r;
        int n, e, rv, best;
        bit done, found;
        logic signed [17:0] resid, amt, rf;
        int sum;
        r = '0;
        n = (n_vertices > NV) ? NV : n_vertices;
        if (b.op == OP_ADD_EDGE)
        begin
            if (b.from_v < n && b.to_v < n)
            begin
                e = b.from_v * NV + b.to_v;
                net_present[e] = 1'b1; net_cap[e] = b.cap; net_flow[e] = '0;
                e = b.to_v * NV + b.from_v;
                net_present[e] = 1'b1; net_cap[e] = '0; net_flow[e] = '0;
            end
        end
        else if (b.op == OP_PREPROC)
        begin
            if (src_v < n)
            begin
                net_height[src_v] = sat_height(n);
                for (int i = 0; i < n; i++)
                begin
                    e = src_v * NV + i;
                    if (net_present[e])
                    begin
                        net_flow[e] = {1'b0, net_cap[e]};
                        net_surplus[i] = {4'd0, net_cap[e]};
                        net_flow[i * NV + src_v] = -$signed({1'b0, net_cap[e]});
                    end
                end
                r.label = net_height[src_v];
            end
        end
        else if (b.op == OP_STEP)
        begin
            if (b.from_v >= n)
                r.st = ST_NO_ARC;
            else
            begin
                done = 1'b0;
                for (int i = 0; i < n && !done; i++)
                begin
                    e = b.from_v * NV + i;
                    if (net_present[e] && net_flow[e] < $signed({1'b0, net_cap[e]})
                        && net_height[b.from_v] > net_height[i])
                    begin
                        resid = $signed({2'b0, net_cap[e]}) - net_flow[e];
                        amt = (resid < $signed({1'b0, net_surplus[b.from_v][16:0]})
                               || net_surplus[b.from_v] > 20'h1FFFF) ? resid
                              : $signed({1'b0, net_surplus[b.from_v][16:0]});
                        if (amt > 18'sd65535) amt = 18'sd65535;
                        net_surplus[b.from_v] = net_surplus[b.from_v] - amt[15:0];
                        sum = net_surplus[i] + amt;
                        net_surplus[i] = (sum > 1048575) ? 20'hFFFFF : sum[19:0];
                        net_flow[e] = 17'(net_flow[e] + amt);
                        rv = i * NV + b.from_v;
                        rf = net_flow[rv] - amt;
                        net_flow[rv] = (rf < -18'sd65536) ? -17'sd65536 : rf[16:0];
                        r.st = ST_PUSHED;
                        r.to_v = 4'(i);
                        r.amount = amt[15:0];
                        done = 1'b1;
                    end
                end
                if (!done)
                begin
                    found = 1'b0;
                    best = 0;
                    for (int i = 0; i < n; i++)
                    begin
                        e = b.from_v * NV + i;
                        if (net_present[e] && net_flow[e] < $signed({1'b0, net_cap[e]}))
                            if (!found || net_height[i] < best)
                            begin
                                best = net_height[i];
                                found = 1'b1;
                            end
                    end
                    if (found)
                    begin
                        net_height[b.from_v] = sat_height(best + 1);
                        r.st = ST_RELABELED;
                    end
                    else
                        r.st = ST_NO_ARC;
                end
                r.label = net_height[b.from_v];
            end
        end
        r.excess = net_surplus[snk_v];
        return r;
    endfunction

    // drop valid only across a gap, so back-to-back beats see one assignment
    task automatic send_beat(beat_in_t b);
        int gap;
        gap = $urandom_range(0, 5);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= b.op;
        from_vertex <= b.from_v;
        to_vertex <= b.to_v;
        edge_capacity <= b.cap;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [4:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_VERTEX_COUNT:  n_vertices = val;
            CFG_SOURCE_VERTEX: src_v = val[3:0];
            CFG_SINK_VERTEX:   snk_v = val[3:0];
            default: ;
        endcase
    endtask

    task automatic drain_results;
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (64) @(posedge clk);
    endtask

    // predict on accept
    always @(posedge clk)
    begin
        beat_in_t b;
        if (in_valid && in_ready)
        begin
            b = '{operation, from_vertex, to_vertex, edge_capacity};
            pending_results.push_back(apply_op(b));
        end
    end

    // output stall and compare
    always @(posedge clk)
    begin
        beat_out_t want;
        if (out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat with nothing expected");
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.st)
                begin
                    $error("status exp %0d got %0d", want.st, status); errors++;
                end
                if (pushed_to !== want.to_v)
                begin
                    $error("pushed_to exp %0d got %0d", want.to_v, pushed_to); errors++;
                end
                if (push_amount !== want.amount)
                begin
                    $error("push_amount exp %0d got %0d", want.amount, push_amount);
                    errors++;
                end
                if (node_label !== want.label)
                begin
                    $error("node_label exp %0d got %0d", want.label, node_label); errors++;
                end
                if (sink_excess !== want.excess)
                begin
                    $error("sink_excess exp %0d got %0d", want.excess, sink_excess);
                    errors++;
                end
            end
            // draw the wait for the next result beat
            out_wait = $urandom_range(0, 5);
        end
        else if (out_valid && out_wait != 0)
            out_wait = out_wait - 1;
        if (stim_done || out_wait == 0)
            out_ready <= 1'b1;
        else
            out_ready <= 1'b0;
    end

    task automatic random_graph_phase(int items, int n);
        beat_in_t b;
        int k;
        for (k = 0; k < items; k++)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4:
                    b = '{OP_ADD_EDGE, 4'($urandom_range(0, n - 1)),
                          4'($urandom_range(0, n - 1)),
                          ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                          16'($urandom_range(0, 40))};
                5:  b = '{OP_PREPROC, 4'($urandom), 4'($urandom), 16'($urandom)};
                6:  b = '{2'($urandom), 4'($urandom), 4'($urandom), 16'($urandom)};
                default:
                    b = '{OP_STEP, 4'($urandom_range(0, n - 1)), 4'($urandom),
                          16'($urandom)};
            endcase
            send_beat(b);
        end
    endtask

    initial
    begin
        row_t rows[$];
        row_t rw;
        int n;
        n_vertices = 5'd16; src_v = 4'd0; snk_v = 4'd1;
        for (int i = 0; i < NV*NV; i++)
        begin
            net_present[i] = 1'b0; net_cap[i] = '0; net_flow[i] = '0;
        end
        for (int i = 0; i < NV; i++)
        begin
            net_height[i] = '0; net_surplus[i] = '0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty step, extremes, self loop, unused opcode, push/relabel
        rw.fixed = 1'b1;
        rw.stim = '{OP_STEP, 4'd0, 4'd0, 16'd0};
        rw.res = '{ST_NO_ARC, 4'd0, 16'd0, 6'd0, 20'd0}; rows.push_back(rw);
        rw.stim = '{OP_NONE, 4'd15, 4'd15, 16'hFFFF};
        rw.res = '{ST_LOADED, 4'd0, 16'd0, 6'd0, 20'd0}; rows.push_back(rw);
        rw.stim = '{OP_ADD_EDGE, 4'd0, 4'd15, 16'hFFFF};
        rw.res = '{ST_LOADED, 4'd0, 16'd0, 6'd0, 20'd0}; rows.push_back(rw);
        rw.stim = '{OP_ADD_EDGE, 4'd7, 4'd7, 16'h1234};
        rw.res = '{ST_LOADED, 4'd0, 16'd0, 6'd0, 20'd0}; rows.push_back(rw);
        rw.fixed = 1'b0;
        rw.stim = '{OP_ADD_EDGE, 4'd15, 4'd1, 16'hFFFF}; rows.push_back(rw);
        rw.stim = '{OP_ADD_EDGE, 4'd0, 4'd2, 16'd10};    rows.push_back(rw);
        rw.stim = '{OP_ADD_EDGE, 4'd2, 4'd1, 16'd4};     rows.push_back(rw);
        rw.stim = '{OP_ADD_EDGE, 4'd2, 4'd15, 16'd0};    rows.push_back(rw);
        rw.stim = '{OP_PREPROC, 4'd9, 4'd9, 16'd0};      rows.push_back(rw);
        rw.stim = '{OP_STEP, 4'd2, 4'd0, 16'd0};         rows.push_back(rw);
        rw.stim = '{OP_STEP, 4'd2, 4'd0, 16'd0};         rows.push_back(rw);
        rw.stim = '{OP_STEP, 4'd2, 4'd0, 16'd0};         rows.push_back(rw);
        rw.stim = '{OP_STEP, 4'd15, 4'd0, 16'd0};        rows.push_back(rw);
        rw.stim = '{OP_STEP, 4'd15, 4'd0, 16'd0};        rows.push_back(rw);
        rw.stim = '{OP_STEP, 4'd15, 4'd0, 16'd0};        rows.push_back(rw);
        rw.stim = '{OP_STEP, 4'd2, 4'd0, 16'd0};         rows.push_back(rw);
        rw.stim = '{OP_STEP, 4'd1, 4'd0, 16'd0};         rows.push_back(rw);
        rw.stim = '{OP_PREPROC, 4'd0, 4'd0, 16'd0};      rows.push_back(rw);
        foreach (rows[i])
        begin
            if (rows[i].fixed)
            begin
                beat_out_t p;
                // literal row agrees with mirror or the mirror is wrong
                p = apply_op(rows[i].stim);
                if (p !== rows[i].res)
                begin
                    $error("row %0d literal exp %h mirror %h", i, rows[i].res, p);
                    errors++;
                end
                // literal rows are idempotent on the mirror, so a second apply is harmless
                send_beat(rows[i].stim);
            end
            else
                send_beat(rows[i].stim);
        end
        drain_results();

        // random phases across settings, extremes included
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: n = 2;
                1: n = 16;
                2: n = 31;
                default: n = $urandom_range(2, 16);
            endcase
            write_reg(CFG_VERTEX_COUNT, 5'(n));
            if (n > 16) n = 16;
            write_reg(CFG_SOURCE_VERTEX,
                      (ph == 1) ? 5'd15 : 5'($urandom_range(0, n - 1)));
            write_reg(CFG_SINK_VERTEX, (ph == 2) ? 5'd15 :
                      (ph == 3) ? 5'({1'b0, 4'($urandom)}) : 5'($urandom_range(0, n - 1)));
            write_reg(CFG_UNUSED, 5'($urandom));
            random_graph_phase(180, n);
            drain_results();
        end
        stim_done = 1'b1;
        drain_results();
        if (errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule
